### sv/bhld_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the baseline hue line detector
package bhld_pkg;

	localparam int DATA_W = 40;
	localparam int HUE_W = 16;
	localparam int SAT_W = 8;
	localparam int LIGHT_W = 8;
	localparam int HSUM_W = 24;
	localparam int SSUM_W = 16;
	localparam int TALLY_W = 8;
	localparam int STEP_W = 5;

	localparam logic [TALLY_W-1:0] DEFAULT_SAMPLES = 8'd10;
	localparam int MARGIN_SHIFT = 3;

	localparam logic [1:0] MODE_DETECT = 2'd0;
	localparam logic [1:0] MODE_SAMPLE = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic REG_ENABLE_MASK = 1'b0;
	localparam logic REG_SAMPLE_COUNT = 1'b1;

	localparam logic [1:0] PH_HUE = 2'd0;
	localparam logic [1:0] PH_SAT = 2'd1;
	localparam logic [1:0] PH_LIGHT = 2'd2;

	localparam logic [STEP_W-1:0] HUE_STEPS = 5'd24;
	localparam logic [STEP_W-1:0] NARROW_STEPS = 5'd16;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_RES  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

endpackage

### sv/baseline_hue_line_detector.sv
`timescale 1ns / 1ps
// baseline hue line detector: per-sensor calibration sums, serial divider, detect compare
// detect, clear and plain sample requests pass from the EXEC state through RES to the output;
// a sample that completes a calibration also passes through the DIV state, since one restoring divider
// forms the three averages one quotient bit per cycle (24 + 16 + 16 steps)
// throughput: one request at a time, accepted the cycle after the result is taken
// reset clears every sensor store, sets enable_mask to 15 and sample_count to 10
module baseline_hue_line_detector
	import bhld_pkg::*;
#(
	parameter int SENSOR_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               s_tvalid,
	output logic               s_tready,
	// sensor[2:0], hue[18:3], saturation[26:19], lightness[34:27], zeros above
	input  logic [DATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [1:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// accepted[0], is_white[1], cal_done[2], baseline_hue[18:3], baseline_sat[26:19],
	// baseline_light[34:27], zeros above
	output logic [DATA_W-1:0]  m_tdata
);

	localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	state_t state_q;

	logic [7:0]         enable_mask_q;
	logic [TALLY_W-1:0] sample_count_q;

	logic [HSUM_W-1:0]  hue_sum_q   [SENSOR_COUNT];
	logic [SSUM_W-1:0]  sat_sum_q   [SENSOR_COUNT];
	logic [SSUM_W-1:0]  light_sum_q [SENSOR_COUNT];
	logic [TALLY_W-1:0] tally_q     [SENSOR_COUNT];
	logic [HUE_W-1:0]   base_hue_q  [SENSOR_COUNT];
	logic [SAT_W-1:0]   base_sat_q  [SENSOR_COUNT];
	logic [LIGHT_W-1:0] base_light_q[SENSOR_COUNT];
	logic               cal_q       [SENSOR_COUNT];

	logic [1:0]         mode_q;
	logic [2:0]         sensor_q;
	logic [HUE_W-1:0]   hue_q;
	logic [SAT_W-1:0]   sat_q;
	logic [LIGHT_W-1:0] light_q;

	logic acc_q, white_q, done_q;

	// divider working registers
	logic [HSUM_W-1:0]  dvd_q;
	logic [TALLY_W-1:0] rem_q;
	logic [TALLY_W-1:0] dvs_q;
	logic [STEP_W-1:0]  step_q;
	logic [1:0]         phase_q;
	logic [SSUM_W-1:0]  sat_new_q;
	logic [SSUM_W-1:0]  light_new_q;

	logic               m_tvalid_q;
	logic [DATA_W-1:0]  m_tdata_q;

	logic [IDX_W-1:0]   idx;
	logic               en;
	logic [HSUM_W-1:0]  hue_new;
	logic [SSUM_W-1:0]  sat_new;
	logic [SSUM_W-1:0]  light_new;
	logic [TALLY_W-1:0] tally_new;
	logic [TALLY_W-1:0] target;
	logic [HUE_W:0]     limit;
	logic [TALLY_W:0]   rem_shift;
	logic               q_bit;
	logic [TALLY_W-1:0] rem_next;
	logic [HSUM_W-1:0]  dvd_next;
	logic               cfg_wr;
	logic [HUE_W-1:0]   out_bh;
	logic [SAT_W-1:0]   out_bs;
	logic [LIGHT_W-1:0] out_bl;

	assign idx = IDX_W'(sensor_q);
	assign en  = (int'(sensor_q) < SENSOR_COUNT) && enable_mask_q[sensor_q];

	assign hue_new   = hue_sum_q[idx] + HSUM_W'(hue_q);
	assign sat_new   = sat_sum_q[idx] + SSUM_W'(sat_q);
	assign light_new = light_sum_q[idx] + SSUM_W'(light_q);
	assign tally_new = tally_q[idx] + 8'd1;
	assign target    = (sample_count_q == '0) ? DEFAULT_SAMPLES : sample_count_q;
	// margin sum kept one bit wider so it cannot wrap
	assign limit     = {1'b0, base_hue_q[idx]} + (HUE_W+1)'(base_hue_q[idx] >> MARGIN_SHIFT);

	// one restoring division step
	assign rem_shift = {rem_q, dvd_q[HSUM_W-1]};
	assign q_bit     = rem_shift >= {1'b0, dvs_q};
	assign rem_next  = q_bit ? TALLY_W'(rem_shift - {1'b0, dvs_q}) : rem_shift[TALLY_W-1:0];
	assign dvd_next  = {dvd_q[HSUM_W-2:0], q_bit};

	assign out_bh = en ? base_hue_q[idx]   : '0;
	assign out_bs = en ? base_sat_q[idx]   : '0;
	assign out_bl = en ? base_light_q[idx] : '0;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_ENABLE_MASK:  prdata = 32'(enable_mask_q);
			REG_SAMPLE_COUNT: prdata = 32'(sample_count_q);
			default:          prdata = '0;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q  <= 8'd15;
			sample_count_q <= DEFAULT_SAMPLES;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ENABLE_MASK:  enable_mask_q  <= pwdata[7:0];
				REG_SAMPLE_COUNT: sample_count_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			mode_q      <= '0;
			sensor_q    <= '0;
			hue_q       <= '0;
			sat_q       <= '0;
			light_q     <= '0;
			acc_q       <= 1'b0;
			white_q     <= 1'b0;
			done_q      <= 1'b0;
			dvd_q       <= '0;
			rem_q       <= '0;
			dvs_q       <= '0;
			step_q      <= '0;
			phase_q     <= PH_HUE;
			sat_new_q   <= '0;
			light_new_q <= '0;
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				hue_sum_q[i]    <= '0;
				sat_sum_q[i]    <= '0;
				light_sum_q[i]  <= '0;
				tally_q[i]      <= '0;
				base_hue_q[i]   <= '0;
				base_sat_q[i]   <= '0;
				base_light_q[i] <= '0;
				cal_q[i]        <= 1'b0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q   <= s_tuser;
						sensor_q <= s_tdata[2:0];
						hue_q    <= s_tdata[18:3];
						sat_q    <= s_tdata[26:19];
						light_q  <= s_tdata[34:27];
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					acc_q   <= 1'b0;
					white_q <= 1'b0;
					done_q  <= 1'b0;
					state_q <= ST_RES;
					if (en) begin
						case (mode_q)
							MODE_DETECT: begin
								if (cal_q[idx]) begin
									acc_q   <= 1'b1;
									white_q <= {1'b0, hue_q} > limit;
								end
							end
							MODE_SAMPLE: begin
								acc_q <= 1'b1;
								if (tally_new >= target) begin
									// sums restart now, the averages follow from the divider
									hue_sum_q[idx]   <= '0;
									sat_sum_q[idx]   <= '0;
									light_sum_q[idx] <= '0;
									tally_q[idx]     <= '0;
									dvd_q            <= hue_new;
									rem_q            <= '0;
									dvs_q            <= tally_new;
									step_q           <= HUE_STEPS;
									phase_q          <= PH_HUE;
									sat_new_q        <= sat_new;
									light_new_q      <= light_new;
									state_q          <= ST_DIV;
								end else begin
									hue_sum_q[idx]   <= hue_new;
									sat_sum_q[idx]   <= sat_new;
									light_sum_q[idx] <= light_new;
									tally_q[idx]     <= tally_new;
								end
							end
							MODE_CLEAR: begin
								acc_q            <= 1'b1;
								hue_sum_q[idx]   <= '0;
								sat_sum_q[idx]   <= '0;
								light_sum_q[idx] <= '0;
								tally_q[idx]     <= '0;
								base_hue_q[idx]  <= '0;
								base_sat_q[idx]  <= '0;
								base_light_q[idx] <= '0;
								cal_q[idx]       <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (step_q == 5'd1) begin
						rem_q <= '0;
						case (phase_q)
							PH_HUE: begin
								base_hue_q[idx] <= dvd_next[HUE_W-1:0];
								dvd_q   <= {sat_new_q, 8'd0};
								step_q  <= NARROW_STEPS;
								phase_q <= PH_SAT;
							end
							PH_SAT: begin
								base_sat_q[idx] <= dvd_next[SAT_W-1:0];
								dvd_q   <= {light_new_q, 8'd0};
								step_q  <= NARROW_STEPS;
								phase_q <= PH_LIGHT;
							end
							default: begin
								base_light_q[idx] <= dvd_next[LIGHT_W-1:0];
								cal_q[idx] <= 1'b1;
								done_q     <= 1'b1;
								state_q    <= ST_RES;
							end
						endcase
					end else begin
						dvd_q  <= dvd_next;
						rem_q  <= rem_next;
						step_q <= step_q - 5'd1;
					end
				end
				ST_RES: begin
					m_tdata_q  <= {5'd0, out_bl, out_bs, out_bh, done_q, white_q, acc_q};
					m_tvalid_q <= 1'b1;
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
